/* design/assert_macros.svh */
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is high.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dbt_pkg.sv */
`default_nettype none

package dbt_pkg;

  localparam int MAX_KEY_LEN_DEF = 8;
  localparam int LETTER_SLOTS    = 8;
  localparam int BYTE_W          = 8;
  localparam int KEY_W           = 64;
  localparam int KLEN_W          = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int OUT_CAP         = 16;
  localparam int CNT_W           = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_KEY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_KEY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD        = 3'd4;

  localparam logic [KLEN_W-1:0] RST_KEY_LEN = 4'd4;
  localparam logic [BYTE_W-1:0] RST_PAD     = 8'd120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH1,
    ST_ROW1,
    ST_ROW2,
    ST_AFTER1,
    ST_FLUSH2,
    ST_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

/* design/double_block_transposition_top.sv */
// Each accepted byte goes into the stage-one row; no new byte is taken until it is done.
// A completed stage-one row is read out in column order into the stage-two row, and every
// completed stage-two row is emitted in column order, holding while the output stalls.
// Message end pads the stage-one row, then the stage-two row, with the pad byte.
// A key letter or length write recomputes that column order, one key letter per cycle.
// Reset (rst, synchronous): keys zero, lengths 4, pad 120, orders identity, rows empty.
`default_nettype none

module double_block_transposition_top
  import dbt_pkg::*;
#(
  parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] plain_byte
  input  wire logic                  s_tlast,   // message_end
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [BYTE_W-1:0]     m_tdata,   // [7:0] cipher_byte
  output logic                       m_tuser,   // [0] run_end
  output logic                       m_tlast,   // message_done
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CAP   = (MAX_KEY_LEN < LETTER_SLOTS) ? MAX_KEY_LEN : LETTER_SLOTS;
  localparam int IDX_W = $clog2(CAP);
  localparam int LEN_W = $clog2(CAP + 1);

  function automatic logic [LEN_W-1:0] eff_len(input logic [KLEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    if (l == '0) begin
      r = LEN_W'(1);
    end else if (int'(l) > CAP) begin
      r = LEN_W'(CAP);
    end else begin
      r = l[LEN_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [KEY_W-1:0]  key1, key2;
  logic [KLEN_W-1:0] klen1, klen2;
  logic [BYTE_W-1:0] pad;
  logic [LEN_W-1:0]  n1, n2;

  // stage storage
  logic [IDX_W-1:0]  order1 [CAP];
  logic [IDX_W-1:0]  order2 [CAP];
  logic [BYTE_W-1:0] store1 [CAP];
  logic [BYTE_W-1:0] store2 [CAP];
  logic [IDX_W-1:0]  fill1, fill2;
  logic [IDX_W-1:0]  j1, j2;

  // sequencer
  seq_state_t        state, state_next;
  seq_state_t        ret, ret_next;
  logic [BYTE_W-1:0] b1;
  logic              last_flag;
  logic [CNT_W-1:0]  cnt;
  logic              pend_valid;
  logic [BYTE_W-1:0] pend_byte;

  // order refresh
  logic              ref_busy;
  logic              ref_sel;
  logic [IDX_W-1:0]  ref_j;
  logic [KEY_W-1:0]  rk_key;
  logic [LEN_W-1:0]  rk_n;
  logic [BYTE_W-1:0] rk_kj;
  logic [IDX_W-1:0]  rank;
  logic              ref_done;

  logic              accept, cfg_we, out_busy;
  logic [LEN_W-1:0]  fill1_inc, fill2_inc;
  logic              row1_full, row2_full, last_j1, last_j2;
  logic [BYTE_W-1:0] rd1, rd2, push2_byte;
  logic              push1, push2, emit, fin, pad1;
  logic              load_beat;

  assign n1 = eff_len(klen1);
  assign n2 = eff_len(klen2);

  assign s_tready  = (state == ST_IDLE) && !ref_busy;
  assign cfg_ready = (state == ST_IDLE) && !ref_busy;
  assign accept    = s_tvalid && s_tready;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_busy  = m_tvalid && !m_tready;

  assign fill1_inc = LEN_W'(fill1) + LEN_W'(1);
  assign fill2_inc = LEN_W'(fill2) + LEN_W'(1);
  assign row1_full = fill1_inc >= n1;
  assign row2_full = fill2_inc >= n2;
  assign last_j1   = LEN_W'(j1) == (n1 - LEN_W'(1));
  assign last_j2   = LEN_W'(j2) == (n2 - LEN_W'(1));

  assign rd1        = store1[order1[j1]];
  assign rd2        = store2[order2[j2]];
  assign push2_byte = (state == ST_FLUSH2) ? pad : rd1;
  assign load_beat  = pend_valid && ((emit && (cnt < CNT_W'(OUT_CAP))) || fin);

  // shared rank unit: place of letter ref_j in the stable sort of the selected key
  always_comb begin
    rk_key = ref_sel ? key2 : key1;
    rk_n   = ref_sel ? n2 : n1;
    rk_kj  = rk_key[8*ref_j +: 8];
    rank   = '0;
    for (int i = 0; i < CAP; i++) begin
      if ((i < int'(rk_n)) &&
          ((rk_key[8*i +: 8] < rk_kj) || ((rk_key[8*i +: 8] == rk_kj) && (i < int'(ref_j)))))
      begin
        rank = rank + IDX_W'(1);
      end
    end
    ref_done = LEN_W'(ref_j) == (rk_n - LEN_W'(1));
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    push1      = 1'b0;
    push2      = 1'b0;
    emit       = 1'b0;
    fin        = 1'b0;
    pad1       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_PUSH1;
      end
      ST_PUSH1: begin
        push1      = 1'b1;
        state_next = row1_full ? ST_ROW1 : ST_AFTER1;
      end
      ST_ROW1: begin
        push2 = 1'b1;
        if (row2_full) begin
          state_next = ST_ROW2;
          ret_next   = last_j1 ? ST_AFTER1 : ST_ROW1;
        end else if (last_j1) begin
          state_next = ST_AFTER1;
        end
      end
      ST_ROW2: begin
        if (!out_busy) begin
          emit = 1'b1;
          if (last_j2) state_next = ret;
        end
      end
      ST_AFTER1: begin
        if (last_flag && (fill1 != '0)) begin
          pad1       = 1'b1;
          state_next = ST_PUSH1;
        end else if (last_flag) begin
          state_next = ST_FLUSH2;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FLUSH2: begin
        if (fill2 != '0) begin
          push2 = 1'b1;
          if (row2_full) begin
            state_next = ST_ROW2;
            ret_next   = ST_FLUSH2;
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // datapath and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fill1      <= '0;
      fill2      <= '0;
      j1         <= '0;
      j2         <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      ref_busy   <= 1'b0;
      ref_sel    <= 1'b0;
      ref_j      <= '0;
      key1       <= '0;
      key2       <= '0;
      klen1      <= RST_KEY_LEN;
      klen2      <= RST_KEY_LEN;
      pad        <= RST_PAD;
      for (int i = 0; i < CAP; i++) begin
        order1[i] <= IDX_W'(i);
        order2[i] <= IDX_W'(i);
      end
    end else begin
      if (accept) begin
        b1        <= s_tdata;
        last_flag <= s_tlast;
        cnt       <= '0;
      end
      if (pad1) b1 <= pad;

      if (push1) begin
        store1[fill1] <= b1;
        if (row1_full) begin
          fill1 <= '0;
          j1    <= '0;
        end else begin
          fill1 <= fill1 + IDX_W'(1);
        end
      end

      if (state == ST_ROW1) j1 <= j1 + IDX_W'(1);

      if (push2) begin
        store2[fill2] <= push2_byte;
        if (row2_full) begin
          fill2 <= '0;
          j2    <= '0;
        end else begin
          fill2 <= fill2 + IDX_W'(1);
        end
      end

      if (emit) begin
        j2 <= j2 + IDX_W'(1);
        if (cnt < CNT_W'(OUT_CAP)) begin
          cnt        <= cnt + CNT_W'(1);
          pend_byte  <= rd2;
          pend_valid <= 1'b1;
        end
      end
      if (fin) pend_valid <= 1'b0;

      // output register: load the pending byte, else drop on take
      if (load_beat) begin
        m_tvalid <= 1'b1;
        m_tdata  <= pend_byte;
        m_tuser  <= fin;
        m_tlast  <= fin && last_flag;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index) inside
          REG_FIRST_KEY, REG_FIRST_LEN: begin
            if (cfg_index == REG_FIRST_KEY) begin
              key1 <= cfg_data;
            end else begin
              klen1 <= cfg_data[KLEN_W-1:0];
            end
            ref_busy <= 1'b1;
            ref_sel  <= 1'b0;
            ref_j    <= '0;
            for (int i = 0; i < CAP; i++) order1[i] <= IDX_W'(i);
          end
          REG_SECOND_KEY, REG_SECOND_LEN: begin
            if (cfg_index == REG_SECOND_KEY) begin
              key2 <= cfg_data;
            end else begin
              klen2 <= cfg_data[KLEN_W-1:0];
            end
            ref_busy <= 1'b1;
            ref_sel  <= 1'b1;
            ref_j    <= '0;
            for (int i = 0; i < CAP; i++) order2[i] <= IDX_W'(i);
          end
          REG_PAD: pad <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end

      if (ref_busy) begin
        if (ref_sel) begin
          order2[rank] <= ref_j;
        end else begin
          order1[rank] <= ref_j;
        end
        if (ref_done) begin
          ref_busy <= 1'b0;
        end else begin
          ref_j <= ref_j + IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/dbt_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module dbt_checker
  import dbt_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [BYTE_W-1:0]    m_tdata,
  input wire logic                 m_tuser,
  input wire logic                 m_tlast
);

  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
  `CHK_IMPL(a_in_implies_cfg, clk, rst, s_tready, cfg_ready, "input ready while configuration port busy")
  `CHK_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input ready right after an accepted beat")
  `CHK_NEXT(a_refresh_blocks, clk, rst, cfg_valid && cfg_ready && (cfg_index == REG_FIRST_KEY || cfg_index == REG_FIRST_LEN || cfg_index == REG_SECOND_KEY || cfg_index == REG_SECOND_LEN), !s_tready && !cfg_ready, "key write did not start order refresh")
  `CHK_IMPL(a_done_is_run_end, clk, rst, m_tvalid && m_tlast, m_tuser, "message end beat without run end")

endmodule

bind double_block_transposition_top dbt_checker u_dbt_checker (.*);

`default_nettype wire

/* bench/double_block_transposition_top_tb.sv */
module double_block_transposition_top_tb;
  import dbt_pkg::*;

  localparam int KEY_SLOTS     = MAX_KEY_LEN_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 45;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher;
    logic              run_end;
    logic              done;
  } cipher_beat_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [BYTE_W-1:0]     plain;
    logic                  last;
    logic [2:0]            ntyped;
    logic [0:3][7:0]       typed;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [BYTE_W-1:0]     m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_ready;

  double_block_transposition_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cipher state, stage 0 is the first transposition, stage 1 the second.
  logic [KEY_W-1:0]  key_letters [2];
  logic [KLEN_W-1:0] key_len [2];
  logic [2:0]        col_order [2][KEY_SLOTS];
  logic [BYTE_W-1:0] row_bytes [2][KEY_SLOTS];
  int                row_fill [2];
  logic [BYTE_W-1:0] pad_value;

  cipher_beat_t cipher_expected[$];
  cipher_beat_t burst[$];
  plan_row_t    plan[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 34;
  int           recv_idle_pct = 78;

  function automatic int stage_width(int s);
    int n;
    n = key_len[s];
    if (n < 1) n = 1;
    if (n > KEY_SLOTS) n = KEY_SLOTS;
    return n;
  endfunction

  // Stable rank of each key letter gives the column read at each output slot.
  function automatic void build_column_order(int s);
    int n;
    int rank;
    logic [7:0] kj;
    logic [7:0] ki;
    n = stage_width(s);
    for (int i = 0; i < KEY_SLOTS; i++) col_order[s][i] = 3'(i);
    for (int j = 0; j < n; j++) begin
      rank = 0;
      kj = key_letters[s][8*j +: 8];
      for (int i = 0; i < n; i++) begin
        ki = key_letters[s][8*i +: 8];
        if (ki < kj || (ki == kj && i < j)) rank++;
      end
      col_order[s][rank] = 3'(j);
    end
  endfunction

  function automatic void push_stage_two(logic [7:0] b);
    int n;
    n = stage_width(1);
    row_bytes[1][row_fill[1] % KEY_SLOTS] = b;
    row_fill[1]++;
    if (row_fill[1] >= n) begin
      for (int j = 0; j < n; j++)
        if (burst.size() < OUT_CAP)
          burst.push_back(cipher_beat_t'{cipher: row_bytes[1][col_order[1][j]],
                                         run_end: 1'b0, done: 1'b0});
      row_fill[1] = 0;
    end
  endfunction

  function automatic void push_stage_one(logic [7:0] b);
    int n;
    n = stage_width(0);
    row_bytes[0][row_fill[0] % KEY_SLOTS] = b;
    row_fill[0]++;
    if (row_fill[0] >= n) begin
      row_fill[0] = 0;
      for (int j = 0; j < n; j++) push_stage_two(row_bytes[0][col_order[0][j]]);
    end
  endfunction

  function automatic void encrypt_byte(logic [7:0] b, logic last);
    int tail;
    burst.delete();
    push_stage_one(b);
    if (last) begin
      while (row_fill[0] != 0) push_stage_one(pad_value);
      while (row_fill[1] != 0) push_stage_two(pad_value);
    end
    if (burst.size() > 0) begin
      tail = burst.size() - 1;
      burst[tail].run_end = 1'b1;
      burst[tail].done = last;
    end
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_FIRST_KEY: begin
        key_letters[0] = v;
        build_column_order(0);
      end
      REG_FIRST_LEN: begin
        key_len[0] = v[KLEN_W-1:0];
        build_column_order(0);
      end
      REG_SECOND_KEY: begin
        key_letters[1] = v;
        build_column_order(1);
      end
      REG_SECOND_LEN: begin
        key_len[1] = v[KLEN_W-1:0];
        build_column_order(1);
      end
      REG_PAD: pad_value = v[BYTE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] b, logic last, int ntyped = 0,
                                         logic [0:3][7:0] typed = '0);
    plan_row_t r;
    r = '0;
    r.plain = b;
    r.last = last;
    r.ntyped = 3'(ntyped);
    r.typed = typed;
    return r;
  endfunction

  // Hold input off until every expected beat is out, then let the block go quiet.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, v);
  endtask

  task automatic send_byte(logic [7:0] b, logic last, int ntyped, logic [0:3][7:0] typed);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    encrypt_byte(b, last);
    if (ntyped == 0) begin
      foreach (burst[i]) cipher_expected.push_back(burst[i]);
    end else begin
      for (int i = 0; i < ntyped; i++)
        cipher_expected.push_back(cipher_beat_t'{cipher: typed[i], run_end: i == ntyped - 1,
                                                 done: last && i == ntyped - 1});
    end
  endtask

  function automatic logic [KEY_W-1:0] random_letters();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    // Narrow alphabet half the time so equal letters are common.
    if ($urandom_range(1) == 0)
      for (int j = 0; j < LETTER_SLOTS; j++) k[8*j +: 8] = 8'h41 + 8'($urandom_range(2));
    return k;
  endfunction

  task automatic randomize_keys();
    logic [CFG_DATA_W-1:0] len_word;
    settle_block();
    write_register(CFG_IDX_W'(REG_UNUSED_LO + $urandom_range(2)), {$urandom, $urandom});
    write_register(REG_FIRST_KEY, random_letters());
    len_word = {$urandom, $urandom};
    len_word[KLEN_W-1:0] = KLEN_W'($urandom_range(15));
    write_register(REG_FIRST_LEN, len_word);
    write_register(REG_SECOND_KEY, random_letters());
    len_word = {$urandom, $urandom};
    len_word[KLEN_W-1:0] = KLEN_W'($urandom_range(15));
    write_register(REG_SECOND_LEN, len_word);
    write_register(REG_PAD, {$urandom, $urandom});
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : check_out
    cipher_beat_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (cipher_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: beat with nothing expected, got cipher_byte=%h run_end=%b done=%b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = cipher_expected.pop_front();
          if (m_tdata !== want.cipher) begin
            mismatch_count++;
            $display("%0t: cipher_byte expected %h got %h", $time, want.cipher, m_tdata);
          end
          if (m_tuser !== want.run_end) begin
            mismatch_count++;
            $display("%0t: run_end expected %b got %b", $time, want.run_end, m_tuser);
          end
          if (m_tlast !== want.done) begin
            mismatch_count++;
            $display("%0t: message_done expected %b got %b", $time, want.done, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    int msg_left;
    logic last;
    for (int s = 0; s < 2; s++) begin
      key_letters[s] = '0;
      key_len[s] = RST_KEY_LEN;
      row_fill[s] = 0;
      build_column_order(s);
    end
    pad_value = RST_PAD;

    // Reset keys tie every letter, so both stages pass rows straight through.
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'hFF, 1'b0));
    plan.push_back(byte_row(8'h55, 1'b0));
    plan.push_back(byte_row(8'hAA, 1'b0, 4, {8'h00, 8'hFF, 8'h55, 8'hAA}));
    plan.push_back(byte_row(8'h11, 1'b1, 4, {8'h11, 8'h78, 8'h78, 8'h78}));
    // Zero lengths act as one: each byte comes straight out, no padding.
    plan.push_back(cfg_row(REG_PAD, 64'h0));
    plan.push_back(cfg_row(REG_FIRST_LEN, 64'h0));
    plan.push_back(cfg_row(REG_SECOND_LEN, 64'hFFFF_FFFF_FFFF_FFF0));
    plan.push_back(byte_row(8'hA5, 1'b0, 1, {8'hA5, 8'h00, 8'h00, 8'h00}));
    plan.push_back(byte_row(8'h5A, 1'b1, 1, {8'h5A, 8'h00, 8'h00, 8'h00}));
    // Descending first key reverses rows; second length above range acts as eight.
    plan.push_back(cfg_row(REG_FIRST_KEY, 64'h0000_0000_4142_4344));
    plan.push_back(cfg_row(REG_FIRST_LEN, 64'h4));
    plan.push_back(cfg_row(REG_SECOND_KEY, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_SECOND_LEN, 64'hF));
    plan.push_back(cfg_row(REG_PAD, 64'hFF));
    plan.push_back(byte_row(8'h01, 1'b0));
    plan.push_back(byte_row(8'h02, 1'b0));
    plan.push_back(byte_row(8'h03, 1'b0));
    plan.push_back(byte_row(8'h04, 1'b0));
    plan.push_back(byte_row(8'h05, 1'b1));
    plan.push_back(cfg_row(REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_UNUSED_HI, 64'h0));
    plan.push_back(cfg_row(REG_PAD, 64'h3C));
    plan.push_back(cfg_row(REG_FIRST_KEY, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_FIRST_LEN, 64'hFFFF_FFFF_FFFF_FFF1));
    plan.push_back(cfg_row(REG_SECOND_KEY, 64'h0102_0304_0506_0708));
    plan.push_back(cfg_row(REG_SECOND_LEN, 64'h8));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(byte_row(8'h7F, 1'b0));
    plan.push_back(byte_row(8'h01, 1'b0));
    plan.push_back(byte_row(8'hFE, 1'b0));
    plan.push_back(byte_row(8'h40, 1'b0));
    plan.push_back(byte_row(8'hBF, 1'b0));
    plan.push_back(byte_row(8'h20, 1'b0));
    plan.push_back(byte_row(8'hC3, 1'b1));
    // Shrink the first row width while three bytes wait in it.
    plan.push_back(cfg_row(REG_FIRST_KEY, 64'h0));
    plan.push_back(cfg_row(REG_FIRST_LEN, 64'h4));
    plan.push_back(cfg_row(REG_SECOND_LEN, 64'h1));
    plan.push_back(byte_row(8'h10, 1'b0));
    plan.push_back(byte_row(8'h20, 1'b0));
    plan.push_back(byte_row(8'h30, 1'b0));
    plan.push_back(cfg_row(REG_FIRST_LEN, 64'h2));
    plan.push_back(byte_row(8'h40, 1'b0));
    plan.push_back(byte_row(8'h50, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) settle_block();
        write_register(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].plain, plan[i].last, plan[i].ntyped, plan[i].typed);
      end
    end

    msg_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      randomize_keys();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) randomize_keys();
        else if ($urandom_range(24) == 0) settle_block();
        if (msg_left == 0) msg_left = $urandom_range(1, 12);
        msg_left--;
        last = (msg_left == 0);
        send_byte(8'($urandom), last, 0, '0);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
